// ===== rtl/tgarle_pkg.sv =====
// Shared types and constants for the TGA RLE pixel decoder.
// No dependencies; used by every module under rtl/.
package tgarle_pkg;

    localparam int unsigned DataW   = 8;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned CfgDatW = 3;
    localparam int unsigned OutDatW = 48;

    localparam logic [7:0] HDR_RUN_BIT    = 8'h80;
    localparam logic [7:0] HDR_COUNT_MASK = 8'h7F;
    localparam logic [7:0] CH5_MASK       = 8'h1F;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_PIXEL_BYTES = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_RLE_ENABLED = 2'd1;

    localparam logic [2:0] PIXEL_BYTES_RESET = 3'd1;

    typedef struct packed {
        logic [7:0] repeat_count;
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] index_value;
        logic       packet_last;
    } t_pixel;

    // one decode result headed for the output register
    typedef struct packed {
        logic   emit;
        t_pixel pix;
    } t_result;

endpackage

// ===== rtl/tgarle_parser.sv =====
// Packet/pixel parser: configuration registers, packet state, pixel assembly.
// Depends on tgarle_pkg.
module tgarle_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tgarle_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [tgarle_pkg::CfgDatW-1:0] i_cfg_data,
    input  logic                          i_accept,
    input  logic [7:0]                    i_byte,
    output tgarle_pkg::t_result           o_result,
    output logic                          o_header
);

    logic [2:0]  r_pixel_bytes;
    logic        r_rle_enabled;
    logic        r_awaiting_header, n_awaiting_header;
    logic        r_run_packet,      n_run_packet;
    logic [7:0]  r_pixels_left,     n_pixels_left;
    logic [1:0]  r_byte_position,   n_byte_position;
    logic [23:0] r_held,            n_held;

    logic [2:0]  eff_size;
    logic [7:0]  b0, b1, b2, b3;
    tgarle_pkg::t_result res;

    always_comb begin
        if (r_pixel_bytes == 3'd0) begin
            eff_size = 3'd1;
        end else if (r_pixel_bytes > 3'd4) begin
            eff_size = 3'd4;
        end else begin
            eff_size = r_pixel_bytes;
        end
    end

    assign o_header = r_rle_enabled && r_awaiting_header;

    always_comb begin
        n_awaiting_header = r_awaiting_header;
        n_run_packet      = r_run_packet;
        n_pixels_left     = r_pixels_left;
        n_byte_position   = r_byte_position;
        n_held            = r_held;
        res               = '0;
        res.pix.repeat_count = 8'd1;
        res.pix.packet_last  = 1'b1;
        b0 = r_held[7:0];
        b1 = r_held[15:8];
        b2 = r_held[23:16];
        b3 = 8'd0;

        if (o_header) begin
            n_run_packet      = (i_byte & tgarle_pkg::HDR_RUN_BIT) != 8'd0;
            n_pixels_left     = (i_byte & tgarle_pkg::HDR_COUNT_MASK) + 8'd1;
            n_awaiting_header = 1'b0;
            n_byte_position   = 2'd0;
            n_held            = '0;
        end else if (({1'b0, r_byte_position} + 3'd1) < eff_size) begin
            // gather another byte of the pixel
            case (r_byte_position)
                2'd0:    n_held[7:0]   = r_held[7:0]   | i_byte;
                2'd1:    n_held[15:8]  = r_held[15:8]  | i_byte;
                2'd2:    n_held[23:16] = r_held[23:16] | i_byte;
                default: n_held        = r_held;
            endcase
            n_byte_position = r_byte_position + 2'd1;
        end else begin
            res.emit = 1'b1;
            case (eff_size)
                3'd1:    b0 = i_byte;
                3'd2:    b1 = i_byte;
                3'd3:    b2 = i_byte;
                default: b3 = i_byte;
            endcase
            case (eff_size)
                3'd1: begin
                    res.pix.index_value = b0;
                end
                3'd2: begin
                    res.pix.red   = {3'b000, b1[6:2]} & tgarle_pkg::CH5_MASK;
                    res.pix.green = {3'b000, b1[1:0], b0[7:5]} & tgarle_pkg::CH5_MASK;
                    res.pix.blue  = b0 & tgarle_pkg::CH5_MASK;
                end
                default: begin
                    res.pix.blue  = b0;
                    res.pix.green = b1;
                    res.pix.red   = b2;
                    res.pix.alpha = (eff_size == 3'd4) ? b3 : 8'd0;
                end
            endcase
            n_byte_position = 2'd0;
            n_held          = '0;

            if (r_rle_enabled) begin
                if (r_run_packet) begin
                    res.pix.repeat_count = (r_pixels_left == 8'd0) ? 8'd1 : r_pixels_left;
                    n_pixels_left     = 8'd0;
                    n_awaiting_header = 1'b1;
                end else if (r_pixels_left <= 8'd1) begin
                    n_pixels_left     = 8'd0;
                    n_awaiting_header = 1'b1;
                end else begin
                    n_pixels_left       = r_pixels_left - 8'd1;
                    res.pix.packet_last = 1'b0;
                end
            end
        end
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_bytes     <= tgarle_pkg::PIXEL_BYTES_RESET;
            r_rle_enabled     <= 1'b1;
            r_awaiting_header <= 1'b1;
            r_run_packet      <= 1'b0;
            r_pixels_left     <= 8'd0;
            r_byte_position   <= 2'd0;
            r_held            <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    tgarle_pkg::CFG_PIXEL_BYTES: r_pixel_bytes <= i_cfg_data;
                    tgarle_pkg::CFG_RLE_ENABLED: r_rle_enabled <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_accept) begin
                r_awaiting_header <= n_awaiting_header;
                r_run_packet      <= n_run_packet;
                r_pixels_left     <= n_pixels_left;
                r_byte_position   <= n_byte_position;
                r_held            <= n_held;
            end
        end
    end

endmodule

// ===== rtl/tgarle_out_reg.sv =====
// Output register: holds one decoded pixel word until the master side takes it.
// Depends on tgarle_pkg.
module tgarle_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  tgarle_pkg::t_pixel  i_pix,
    input  logic                i_tready,
    output logic                o_tvalid,
    output tgarle_pkg::t_pixel  o_pix,
    output logic                o_can_load
);

    logic               r_valid;
    tgarle_pkg::t_pixel r_pix;

    // free when empty or when the held word leaves this cycle
    assign o_can_load = !r_valid || i_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pix <= i_pix;
        end
    end

    assign o_tvalid = r_valid;
    assign o_pix    = r_pix;

endmodule

// ===== rtl/tga_rle_pixel_decoder.sv =====
// TGA RLE pixel decoder: takes one byte of TGA pixel data per cycle and gives one word per
// completed pixel, with its repeat count, so a whole run packet yields a single word.
// Header and non-final pixel bytes yield no word. The block sustains one byte per clock;
// each accepted byte is decoded by the parser in the same cycle and lands in the output
// register. Input stalls only while that register holds a word the master has not taken.
// The user must write configuration only while idle; the block does not enforce it.
// Depends on tgarle_pkg, tgarle_parser and tgarle_out_reg.
module tga_rle_pixel_decoder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tgarle_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [tgarle_pkg::CfgDatW-1:0] i_cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [tgarle_pkg::DataW-1:0]   s_tdata,   // data_byte
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // index_value, red, green, blue, alpha, repeat_count (low to high)
    output logic [tgarle_pkg::OutDatW-1:0] m_tdata,
    output logic                           m_tlast    // packet_last
);

    logic                accept;
    logic                can_load;
    logic                header;
    tgarle_pkg::t_result result;
    tgarle_pkg::t_pixel  out_pix;

    assign s_tready = can_load;
    assign accept   = s_tvalid && s_tready;

    tgarle_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_byte      (s_tdata),
        .o_result    (result),
        .o_header    (header)
    );

    tgarle_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept && result.emit),
        .i_pix      (result.pix),
        .i_tready   (m_tready),
        .o_tvalid   (m_tvalid),
        .o_pix      (out_pix),
        .o_can_load (can_load)
    );

    assign m_tdata = {out_pix.repeat_count, out_pix.alpha, out_pix.blue,
                      out_pix.green, out_pix.red, out_pix.index_value};
    assign m_tlast = out_pix.packet_last;

`ifndef SYNTH
    a_repeat_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[47:40] != 8'd0))
        else $error("repeat_count of zero on output word");

    a_run_ends_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && (m_tdata[47:40] > 8'd1)) |-> m_tlast)
        else $error("repeated pixel does not end its packet");

    a_header_no_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && header && (!m_tvalid || m_tready)) |=> !m_tvalid)
        else $error("header byte produced an output word");

    a_word_needs_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!m_tvalid && !accept) |=> !m_tvalid)
        else $error("output word appeared without an accepted byte");
`endif

endmodule

// ===== tb/tga_rle_checker.sv =====
// Checker for the TGA RLE pixel decoder: watches the config port and both streams,
// predicts every pixel word from the accepted bytes and compares it field by field.
// Depends on tgarle_pkg for the pixel struct, the register indexes and header constants.
`timescale 1ns / 1ps

module tga_rle_checker
    import tgarle_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDatW-1:0]  i_cfg_data,
    input  logic                i_s_tvalid,
    input  logic                i_s_tready,
    input  logic [DataW-1:0]    i_s_tdata,
    input  logic                i_m_tvalid,
    input  logic                i_m_tready,
    input  logic [OutDatW-1:0]  i_m_tdata,
    input  logic                i_m_tlast,
    output int                  o_fail_count = 0,
    output int                  o_pending = 0
);

    // predictor copy of the registers and the packet state
    logic [2:0]  pix_size_cfg;
    logic        rle_on_cfg;
    logic        want_header;
    logic        run_pkt;
    logic [7:0]  pixels_left;
    logic [1:0]  byte_pos;
    logic [23:0] held_bytes;

    t_pixel      pending_pixels[$];
    int          mismatches = 0;

    task automatic decode_byte(input logic [7:0] d, output bit emit, output t_pixel px);
        int unsigned n;
        logic [7:0]  b0, b1, b2, b3;
        logic [15:0] w;
        emit = 1'b0;
        px = '0;
        if (pix_size_cfg == 3'd0) n = 1;
        else if (pix_size_cfg > 3'd4) n = 4;
        else n = pix_size_cfg;

        if (rle_on_cfg && want_header) begin
            run_pkt = (d & HDR_RUN_BIT) != 8'd0;
            pixels_left = (d & HDR_COUNT_MASK) + 8'd1;
            want_header = 1'b0;
            byte_pos = 2'd0;
            held_bytes = '0;
        end else if (int'(byte_pos) + 1 < n) begin
            held_bytes = held_bytes | (24'(d) << (8 * byte_pos));
            byte_pos = byte_pos + 2'd1;
        end else begin
            b0 = held_bytes[7:0];
            b1 = held_bytes[15:8];
            b2 = held_bytes[23:16];
            b3 = 8'd0;
            // the final byte lands at the slot of the current size
            case (n)
                1: b0 = d;
                2: b1 = d;
                3: b2 = d;
                default: b3 = d;
            endcase
            if (n == 1) begin
                px.index_value = b0;
            end else if (n == 2) begin
                w = {b1, b0};
                px.red   = 8'(w >> 10) & CH5_MASK;
                px.green = 8'(w >> 5) & CH5_MASK;
                px.blue  = 8'(w) & CH5_MASK;
            end else begin
                px.blue  = b0;
                px.green = b1;
                px.red   = b2;
                if (n == 4) px.alpha = b3;
            end
            byte_pos = 2'd0;
            held_bytes = '0;
            px.repeat_count = 8'd1;
            px.packet_last = 1'b1;
            if (rle_on_cfg) begin
                if (run_pkt) begin
                    px.repeat_count = (pixels_left == 8'd0) ? 8'd1 : pixels_left;
                    pixels_left = 8'd0;
                    want_header = 1'b1;
                end else if (pixels_left <= 8'd1) begin
                    pixels_left = 8'd0;
                    want_header = 1'b1;
                end else begin
                    pixels_left = pixels_left - 8'd1;
                    px.packet_last = 1'b0;
                end
            end
            emit = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_pixel got;
        t_pixel want;
        bit     emit;
        if (!i_rst_n) begin
            pix_size_cfg = PIXEL_BYTES_RESET;
            rle_on_cfg = 1'b1;
            want_header = 1'b1;
            run_pkt = 1'b0;
            pixels_left = 8'd0;
            byte_pos = 2'd0;
            held_bytes = '0;
            pending_pixels.delete();
        end else begin
            // compare first: the output is registered, so a word never belongs
            // to the byte taken at the same edge
            if (i_m_tvalid && i_m_tready) begin
                got.index_value  = i_m_tdata[7:0];
                got.red          = i_m_tdata[15:8];
                got.green        = i_m_tdata[23:16];
                got.blue         = i_m_tdata[31:24];
                got.alpha        = i_m_tdata[39:32];
                got.repeat_count = i_m_tdata[47:40];
                got.packet_last  = i_m_tlast;
                if (pending_pixels.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: unexpected word idx=%h r=%h g=%h b=%h a=%h rep=%0d last=%b",
                                 $realtime, got.index_value, got.red, got.green, got.blue,
                                 got.alpha, got.repeat_count, got.packet_last);
                    mismatches++;
                end else begin
                    want = pending_pixels.pop_front();
                    if (got.index_value != want.index_value || got.red != want.red ||
                        got.green != want.green || got.blue != want.blue ||
                        got.alpha != want.alpha || got.repeat_count != want.repeat_count ||
                        got.packet_last != want.packet_last) begin
                        if (mismatches < 10) begin
                            $display("%0t: pixel mismatch", $realtime);
                            $display("  exp idx=%h r=%h g=%h b=%h a=%h rep=%0d last=%b",
                                     want.index_value, want.red, want.green, want.blue,
                                     want.alpha, want.repeat_count, want.packet_last);
                            $display("  got idx=%h r=%h g=%h b=%h a=%h rep=%0d last=%b",
                                     got.index_value, got.red, got.green, got.blue,
                                     got.alpha, got.repeat_count, got.packet_last);
                        end
                        mismatches++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PIXEL_BYTES: pix_size_cfg = i_cfg_data;
                    CFG_RLE_ENABLED: rle_on_cfg = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                decode_byte(i_s_tdata, emit, want);
                if (emit) pending_pixels.push_back(want);
            end
        end
        o_pending <= pending_pixels.size();
        o_fail_count <= mismatches;
    end

endmodule

// ===== tb/tb.sv =====
// Top of the TGA RLE pixel decoder testbench: clock, reset, byte stimulus and verdict.
// Depends on tgarle_pkg, the decoder RTL and tga_rle_checker.
`timescale 1ns / 1ps

module tb;
    import tgarle_pkg::*;

    localparam int          CycleLimit  = 100000;
    localparam int          RandomBytes = 1400;
    localparam logic [CfgIdxW-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_SPARE_3 = 2'd3;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [CfgIdxW-1:0] cfg_index = '0;
    logic [CfgDatW-1:0] cfg_data = '0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [DataW-1:0]   s_tdata = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [OutDatW-1:0] m_tdata;
    logic               m_tlast;

    int                 fail_count;
    int                 pending;
    int                 cycles = 0;
    int                 bytes_sent = 0;
    int                 random_start;
    logic               calm = 1'b0;
    logic [2:0]         pick_size;
    logic               pick_rle;
    int                 r;

    always #6 clk = ~clk;

    tga_rle_pixel_decoder DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    tga_rle_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tlast   (m_tlast),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // output side: stall about 7 percent of the time, never during the calm stretch
    always @(posedge clk) begin
        m_tready <= calm || ($urandom_range(99) >= 7);
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] b);
        while (!calm && $urandom_range(99) < 7) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        bytes_sent++;
    endtask

    // hold the input until every predicted word is out, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic reg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    task automatic set_mode(input logic [2:0] size, input logic rle, input bit poke_spare);
        drain();
        if (poke_spare) begin
            reg_write(CFG_SPARE_2, 3'h7);
            reg_write(CFG_SPARE_3, 3'h0);
        end
        reg_write(CFG_PIXEL_BYTES, size);
        reg_write(CFG_RLE_ENABLED, {2'b00, rle});
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(input logic [2:0] size, input logic rle, input int budget);
        int         start;
        int         n;
        int         npix;
        logic [7:0] hdr;
        start = bytes_sent;
        n = (size == 3'd0) ? 1 : (size > 3'd4) ? 4 : int'(size);
        while (bytes_sent - start < budget) begin
            calm <= (bytes_sent - random_start >= 500) && (bytes_sent - random_start < 800);
            if ($urandom_range(99) < 8) begin
                push_byte(8'($urandom));
            end else if (rle) begin
                hdr = 8'($urandom_range(7));
                if ($urandom_range(15) == 0) hdr = 8'($urandom_range(127));
                if ($urandom_range(1) != 0) hdr = hdr | HDR_RUN_BIT;
                push_byte(hdr);
                npix = ((hdr & HDR_RUN_BIT) != 8'd0) ? 1 : int'(hdr & HDR_COUNT_MASK) + 1;
                repeat (npix * n) push_byte(8'($urandom));
            end else begin
                repeat (n) push_byte(8'($urandom));
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setting: one byte per pixel, RLE on
        push_byte(8'h00); push_byte(8'h00);
        push_byte(8'hFF); push_byte(8'hFF);
        push_byte(8'h02); push_byte(8'h01); push_byte(8'h80); push_byte(8'h7F);

        // 5:5:5 with the spare bit 15 set, then all-zero and mixed channels
        set_mode(3'd2, 1'b1, 1'b1);
        push_byte(8'h80); push_byte(8'hFF); push_byte(8'hFF);
        push_byte(8'h01); push_byte(8'h00); push_byte(8'h80); push_byte(8'h1F); push_byte(8'h7C);

        set_mode(3'd4, 1'b0, 1'b0);
        push_byte(8'h10); push_byte(8'h20); push_byte(8'h30); push_byte(8'h40);

        // shrink the pixel size while a pixel is half gathered
        set_mode(3'd7, 1'b1, 1'b0);
        push_byte(8'h00); push_byte(8'h11); push_byte(8'h22);
        set_mode(3'd2, 1'b1, 1'b0);
        push_byte(8'h33);

        // RLE off in the middle of a raw packet, then resume it
        set_mode(3'd0, 1'b1, 1'b0);
        push_byte(8'h03); push_byte(8'hAA);
        set_mode(3'd1, 1'b0, 1'b0);
        push_byte(8'h55);
        set_mode(3'd1, 1'b1, 1'b0);
        push_byte(8'hC3); push_byte(8'h3C); push_byte(8'h96);

        random_start = bytes_sent;
        while (bytes_sent - random_start < RandomBytes) begin
            r = $urandom_range(9);
            if (r < 8) pick_size = 3'(1 + r % 4);
            else if ($urandom_range(1) != 0) pick_size = 3'd0;
            else pick_size = 3'($urandom_range(7, 5));
            pick_rle = ($urandom_range(99) < 80);
            set_mode(pick_size, pick_rle, 1'b0);
            random_phase(pick_size, pick_rle, $urandom_range(160, 40));
        end
        calm <= 1'b0;

        drain();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
